@@ rtl/core/backoff_segmented_transmitter_defines.svh @@
// ----------------------------------------------------------------------------
// backoff segmented transmitter assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BACKOFF_SEGMENTED_TRANSMITTER_DEFINES_SVH
`define BACKOFF_SEGMENTED_TRANSMITTER_DEFINES_SVH
`ifndef SYNTHESIS
`define BST_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define BST_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`define BST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");
`else
`define BST_ASSERT(label, clk, rst, prop)
`define BST_ASSERT_IMP(label, clk, rst, ante, cons)
`define BST_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg
// shared constants, types and helpers of the segmented backoff transmitter
// ----------------------------------------------------------------------------
package bst_pkg;

   localparam int MaxPackages   = 4;
   localparam int MaxWindowLog2 = 10;
   localparam int PkgIdxWidth   = (MaxPackages > 1) ? $clog2(MaxPackages) : 1;

   localparam int FuncWidth    = 3;
   localparam int BitsWidth    = 16;
   localparam int DrawWidth    = 10;
   localparam int LogWidth     = 4;
   localparam int CountWidth   = 3;
   localparam int BackoffWidth = 11;
   localparam int StatWidth    = 16;
   localparam int CsrIdxWidth  = 3;
   localparam int CsrDataWidth = 16;

   // event codes
   localparam logic [FuncWidth-1:0] FuncTick      = 3'd0;
   localparam logic [FuncWidth-1:0] FuncTransmit  = 3'd1;
   localparam logic [FuncWidth-1:0] FuncCollision = 3'd2;
   localparam logic [FuncWidth-1:0] FuncLoss      = 3'd3;
   localparam logic [FuncWidth-1:0] FuncRestart   = 3'd4;
   localparam logic [FuncWidth-1:0] FuncNewMsg    = 3'd5;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrPkgCount = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrPkgBits0 = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrPkgBits1 = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrPkgBits2 = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrPkgBits3 = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CsrInitWin  = 3'd5;
   localparam logic [CsrIdxWidth-1:0] CsrMaxWin   = 3'd6;

   typedef struct packed {
      logic                    access_granted;
      logic [BitsWidth-1:0]    bits_sent;
      logic                    package_done;
      logic                    message_done;
      logic                    status;
      logic [BackoffWidth-1:0] backoff_left;
      logic [StatWidth-1:0]    collision_total;
      logic [StatWidth-1:0]    loss_total;
      logic [StatWidth-1:0]    sent_total;
   } rsp_type;

   function automatic logic [StatWidth-1:0] sat_inc(input logic [StatWidth-1:0] v);
      return (v == {StatWidth{1'b1}}) ? v : v + StatWidth'(1);
   endfunction

   function automatic logic [LogWidth-1:0] clamp_log2(input logic [LogWidth-1:0] v);
      return (v > LogWidth'(MaxWindowLog2)) ? LogWidth'(MaxWindowLog2) : v;
   endfunction

endpackage

@@ rtl/core/bst_req_if.sv @@
// ----------------------------------------------------------------------------
// bst_req_if
// event channel into the transmitter: valid/ready plus event payload
// ----------------------------------------------------------------------------
interface bst_req_if;
   import bst_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FuncWidth-1:0] func;
   logic [BitsWidth-1:0] capacity_bits;
   logic [DrawWidth-1:0] random_draw;

   modport source (output valid, output func, output capacity_bits,
                   output random_draw, input ready);
   modport sink   (input valid, input func, input capacity_bits,
                   input random_draw, output ready);
endinterface

@@ rtl/core/bst_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bst_rsp_if
// result channel out of the transmitter: valid/ready plus result payload
// ----------------------------------------------------------------------------
interface bst_rsp_if;
   import bst_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    access_granted;
   logic [BitsWidth-1:0]    bits_sent;
   logic                    package_done;
   logic                    message_done;
   logic                    status;
   logic [BackoffWidth-1:0] backoff_left;
   logic [StatWidth-1:0]    collision_total;
   logic [StatWidth-1:0]    loss_total;
   logic [StatWidth-1:0]    sent_total;

   modport source (output valid, output access_granted, output bits_sent,
                   output package_done, output message_done, output status,
                   output backoff_left, output collision_total, output loss_total,
                   output sent_total, input ready);
   modport sink   (input valid, input access_granted, input bits_sent,
                   input package_done, input message_done, input status,
                   input backoff_left, input collision_total, input loss_total,
                   input sent_total, output ready);
endinterface

@@ rtl/core/backoff_segmented_transmitter.sv @@
// ----------------------------------------------------------------------------
// backoff_segmented_transmitter
// per-message transmit engine: package segmentation, exponential backoff
// and saturating statistics, one event per beat
// ----------------------------------------------------------------------------
// an accepted event beat is held in the input register, and its result in the output register
// throughput: one event per cycle while the result channel takes its beats
// an output register and the input register let the next beat in while a result waits
// reset (synchronous, active high) empties both stages, clears message state and
// counters, and loads the register defaults (one package of one bit, windows 1 and 1024)
// ----------------------------------------------------------------------------
`include "backoff_segmented_transmitter_defines.svh"

module backoff_segmented_transmitter (
   input  logic                                clock,
   input  logic                                reset,
   bst_req_if.sink                             req_chan,
   bst_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bst_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bst_pkg::CsrDataWidth-1:0]    csr_wr_data
);
   import bst_pkg::*;

   // configuration
   logic [CountWidth-1:0] pkg_count_ff;
   logic [BitsWidth-1:0]  pkg_bits_ff [MaxPackages];
   logic [LogWidth-1:0]   init_win_ff;
   logic [LogWidth-1:0]   max_win_ff;

   // input stage
   logic                 s1_valid_ff, s1_valid_in;
   logic [FuncWidth-1:0] s1_func_ff;
   logic [BitsWidth-1:0] s1_cap_ff;
   logic [DrawWidth-1:0] s1_draw_ff;

   // message state
   logic [CountWidth-1:0]   pkg_idx_ff, pkg_idx_in;
   logic [BitsWidth-1:0]    remaining_ff, remaining_in;
   logic                    finished_ff, finished_in;
   logic [LogWidth-1:0]     window_ff, window_in;
   logic [BackoffWidth-1:0] backoff_ff, backoff_in;
   logic [MaxPackages-1:0]  loss_marks_ff, loss_marks_in;
   logic [StatWidth-1:0]    coll_cnt_ff, coll_cnt_in;
   logic [StatWidth-1:0]    loss_cnt_ff, loss_cnt_in;
   logic [StatWidth-1:0]    sent_cnt_ff, sent_cnt_in;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic out_free;
   logic req_fire;
   logic s1_fire;

   logic [CountWidth-1:0]   eff_count;
   logic [CountWidth-1:0]   idx_next;
   logic [LogWidth-1:0]     wl;
   logic [LogWidth-1:0]     mx;
   logic [LogWidth-1:0]     wl_up;
   logic [BackoffWidth-1:0] draw_mask;
   logic                    granted;
   logic [BitsWidth-1:0]    sent;
   logic                    pdone;
   logic                    status;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign s1_fire        = s1_valid_ff && out_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // out-of-range package counts fold into 1..MaxPackages
   always_comb begin
      if (pkg_count_ff == '0) begin
         eff_count = CountWidth'(1);
      end else if (pkg_count_ff > CountWidth'(MaxPackages)) begin
         eff_count = CountWidth'(MaxPackages);
      end else begin
         eff_count = pkg_count_ff;
      end
   end

   assign idx_next  = pkg_idx_ff + CountWidth'(1);
   assign wl        = clamp_log2(window_ff);
   assign mx        = clamp_log2(max_win_ff);
   assign wl_up     = wl + LogWidth'(1);
   assign draw_mask = (BackoffWidth'(1) << wl) - BackoffWidth'(1);

   always_comb begin
      pkg_idx_in    = pkg_idx_ff;
      remaining_in  = remaining_ff;
      finished_in   = finished_ff;
      window_in     = window_ff;
      backoff_in    = backoff_ff;
      loss_marks_in = loss_marks_ff;
      coll_cnt_in   = coll_cnt_ff;
      loss_cnt_in   = loss_cnt_ff;
      sent_cnt_in   = sent_cnt_ff;
      granted       = 1'b0;
      sent          = '0;
      pdone         = 1'b0;
      status        = 1'b0;

      unique case (s1_func_ff)
         FuncTick: begin
            if (backoff_ff == '0) begin
               granted = 1'b1;
            end else begin
               backoff_in = backoff_ff - BackoffWidth'(1);
            end
         end
         FuncTransmit: begin
            if (finished_ff) begin
               status = 1'b1;
            end else if (s1_cap_ff >= remaining_ff) begin
               sent        = remaining_ff;
               pdone       = 1'b1;
               sent_cnt_in = sat_inc(sent_cnt_ff);
               pkg_idx_in  = idx_next;
               // compare one bit wider so index 7 plus one does not wrap
               if ({1'b0, pkg_idx_ff} + (CountWidth + 1)'(1) >= {1'b0, eff_count}) begin
                  remaining_in = '0;
                  finished_in  = 1'b1;
               end else begin
                  remaining_in = pkg_bits_ff[idx_next[PkgIdxWidth-1:0]];
               end
            end else begin
               remaining_in = remaining_ff - s1_cap_ff;
               sent         = s1_cap_ff;
            end
         end
         FuncCollision: begin
            backoff_in  = BackoffWidth'(1) + ({1'b0, s1_draw_ff} & draw_mask);
            window_in   = (wl_up < mx) ? wl_up : mx;
            coll_cnt_in = sat_inc(coll_cnt_ff);
         end
         FuncLoss: begin
            if (finished_ff) begin
               status = 1'b1;
            end else if (!loss_marks_ff[pkg_idx_ff[PkgIdxWidth-1:0]]) begin
               loss_marks_in[pkg_idx_ff[PkgIdxWidth-1:0]] = 1'b1;
               loss_cnt_in = sat_inc(loss_cnt_ff);
            end
         end
         FuncRestart: begin
            if (finished_ff) begin
               status = 1'b1;
            end else begin
               pkg_idx_in    = '0;
               backoff_in    = '0;
               remaining_in  = pkg_bits_ff[0];
               loss_marks_in = '0;
               window_in     = clamp_log2(init_win_ff);
            end
         end
         FuncNewMsg: begin
            pkg_idx_in    = '0;
            backoff_in    = '0;
            remaining_in  = pkg_bits_ff[0];
            loss_marks_in = '0;
            window_in     = clamp_log2(init_win_ff);
            finished_in   = 1'b0;
            coll_cnt_in   = '0;
            loss_cnt_in   = '0;
            sent_cnt_in   = '0;
         end
         default: begin
            // unused event codes leave everything as it is
         end
      endcase

      rsp_in.access_granted  = granted;
      rsp_in.bits_sent       = sent;
      rsp_in.package_done    = pdone;
      rsp_in.message_done    = finished_in;
      rsp_in.status          = status;
      rsp_in.backoff_left    = backoff_in;
      rsp_in.collision_total = coll_cnt_in;
      rsp_in.loss_total      = loss_cnt_in;
      rsp_in.sent_total      = sent_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pkg_count_ff <= CountWidth'(1);
         for (int i = 0; i < MaxPackages; i++) begin
            pkg_bits_ff[i] <= BitsWidth'(1);
         end
         init_win_ff <= '0;
         max_win_ff  <= LogWidth'(MaxWindowLog2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrPkgCount: pkg_count_ff   <= csr_wr_data[CountWidth-1:0];
            CsrPkgBits0: pkg_bits_ff[0] <= csr_wr_data[BitsWidth-1:0];
            CsrPkgBits1: pkg_bits_ff[1] <= csr_wr_data[BitsWidth-1:0];
            CsrPkgBits2: pkg_bits_ff[2] <= csr_wr_data[BitsWidth-1:0];
            CsrPkgBits3: pkg_bits_ff[3] <= csr_wr_data[BitsWidth-1:0];
            CsrInitWin:  init_win_ff    <= csr_wr_data[LogWidth-1:0];
            CsrMaxWin:   max_win_ff     <= csr_wr_data[LogWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pkg_idx_ff    <= '0;
         remaining_ff  <= '0;
         finished_ff   <= 1'b0;
         window_ff     <= '0;
         backoff_ff    <= '0;
         loss_marks_ff <= '0;
         coll_cnt_ff   <= '0;
         loss_cnt_ff   <= '0;
         sent_cnt_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            pkg_idx_ff    <= pkg_idx_in;
            remaining_ff  <= remaining_in;
            finished_ff   <= finished_in;
            window_ff     <= window_in;
            backoff_ff    <= backoff_in;
            loss_marks_ff <= loss_marks_in;
            coll_cnt_ff   <= coll_cnt_in;
            loss_cnt_ff   <= loss_cnt_in;
            sent_cnt_ff   <= sent_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_func_ff <= req_chan.func;
         s1_cap_ff  <= req_chan.capacity_bits;
         s1_draw_ff <= req_chan.random_draw;
      end
      if (s1_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.access_granted  = rsp_ff.access_granted;
   assign rsp_chan.bits_sent       = rsp_ff.bits_sent;
   assign rsp_chan.package_done    = rsp_ff.package_done;
   assign rsp_chan.message_done    = rsp_ff.message_done;
   assign rsp_chan.status          = rsp_ff.status;
   assign rsp_chan.backoff_left    = rsp_ff.backoff_left;
   assign rsp_chan.collision_total = rsp_ff.collision_total;
   assign rsp_chan.loss_total      = rsp_ff.loss_total;
   assign rsp_chan.sent_total      = rsp_ff.sent_total;

   // an event leaving the input stage always lands a result beat
   `BST_ASSERT_NEXT(a_fire_gives_rsp, clock, reset, s1_fire, rsp_valid_ff)
   // backoff never exceeds one plus the largest window mask
   `BST_ASSERT(a_backoff_range, clock, reset, backoff_ff <= BackoffWidth'(1 << MaxWindowLog2))
   // an unfinished message always points at a real package
   `BST_ASSERT_IMP(a_idx_range, clock, reset, !finished_ff, pkg_idx_ff < CountWidth'(MaxPackages))
   // a refused event moves no bits
   `BST_ASSERT_IMP(a_status_quiet, clock, reset, rsp_valid_ff && rsp_ff.status,
                   rsp_ff.bits_sent == '0 && !rsp_ff.package_done)
   // a completed package is always counted
   `BST_ASSERT_IMP(a_done_counted, clock, reset, rsp_valid_ff && rsp_ff.package_done,
                   rsp_ff.sent_total != '0)

endmodule

@@ dv/tb_backoff_segmented_transmitter.sv @@
// ----------------------------------------------------------------------------
// tb_backoff_segmented_transmitter
// drives events into the segmented backoff transmitter under random sender
// and receiver stalls, predicts every result beat with a behavioural engine
// model and compares the beats field by field
// ----------------------------------------------------------------------------
module tb_backoff_segmented_transmitter;
   timeunit 1ns;
   timeprecision 1ps;
   import bst_pkg::*;

   localparam int CycleLimit = 100_000;

   // event codes the block ignores
   localparam logic [FuncWidth-1:0] FuncSpareA = 3'd6;
   localparam logic [FuncWidth-1:0] FuncSpareB = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wr_data = '0;

   bst_req_if req_if ();
   bst_rsp_if rsp_if ();

   backoff_segmented_transmitter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // engine model: configuration copy
   logic [CountWidth-1:0] cfg_pkg_count;
   logic [BitsWidth-1:0]  cfg_pkg_bits [4];
   logic [LogWidth-1:0]   cfg_init_win;
   logic [LogWidth-1:0]   cfg_max_win;

   // engine model: message state
   logic [2:0]              eng_index;
   logic [BitsWidth-1:0]    eng_remaining;
   logic                    eng_finished;
   logic [LogWidth-1:0]     eng_window;
   logic [BackoffWidth-1:0] eng_backoff;
   logic                    eng_marks [4];
   logic [StatWidth-1:0]    eng_collisions;
   logic [StatWidth-1:0]    eng_losses;
   logic [StatWidth-1:0]    eng_sent;

   rsp_type     tx_reports [$];
   int          failures = 0;
   int          events_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int unsigned cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(negedge clock) rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);

   function automatic int packages_in_msg();
      if (cfg_pkg_count == '0) return 1;
      if (int'(cfg_pkg_count) > MaxPackages) return MaxPackages;
      return int'(cfg_pkg_count);
   endfunction

   function automatic logic [LogWidth-1:0] window_cap(input logic [LogWidth-1:0] v);
      return (int'(v) > MaxWindowLog2) ? LogWidth'(MaxWindowLog2) : v;
   endfunction

   function automatic logic [StatWidth-1:0] stat_bump(input logic [StatWidth-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic void load_first_package();
      eng_index     = '0;
      eng_backoff   = '0;
      eng_remaining = cfg_pkg_bits[0];
      for (int i = 0; i < 4; i++) eng_marks[i] = 1'b0;
      eng_window    = window_cap(cfg_init_win);
   endfunction

   function automatic rsp_type advance_engine(input logic [FuncWidth-1:0] func,
                                              input logic [BitsWidth-1:0] cap,
                                              input logic [DrawWidth-1:0] draw);
      rsp_type                 r;
      logic [LogWidth-1:0]     wl;
      logic [LogWidth-1:0]     mx;
      logic [BackoffWidth-1:0] mask;
      r = '0;
      case (func)
         FuncTick: begin
            if (eng_backoff == '0) r.access_granted = 1'b1;
            else eng_backoff = eng_backoff - 1'b1;
         end
         FuncTransmit: begin
            if (eng_finished) begin
               r.status = 1'b1;
            end else if (cap >= eng_remaining) begin
               r.bits_sent    = eng_remaining;
               r.package_done = 1'b1;
               eng_sent       = stat_bump(eng_sent);
               // a count lowered below the index also ends the message here
               if (int'(eng_index) + 1 >= packages_in_msg()) begin
                  eng_index     = eng_index + 1'b1;
                  eng_remaining = '0;
                  eng_finished  = 1'b1;
               end else begin
                  eng_index     = eng_index + 1'b1;
                  eng_remaining = cfg_pkg_bits[eng_index[1:0]];
               end
            end else begin
               eng_remaining = eng_remaining - cap;
               r.bits_sent   = cap;
            end
         end
         FuncCollision: begin
            wl             = window_cap(eng_window);
            mx             = window_cap(cfg_max_win);
            mask           = (BackoffWidth'(1) << wl) - 1'b1;
            eng_backoff    = BackoffWidth'(1) + (BackoffWidth'(draw) & mask);
            eng_window     = (int'(wl) + 1 < int'(mx)) ? wl + 1'b1 : mx;
            eng_collisions = stat_bump(eng_collisions);
         end
         FuncLoss: begin
            if (eng_finished) begin
               r.status = 1'b1;
            end else if (!eng_marks[eng_index[1:0]]) begin
               eng_marks[eng_index[1:0]] = 1'b1;
               eng_losses = stat_bump(eng_losses);
            end
         end
         FuncRestart: begin
            if (eng_finished) r.status = 1'b1;
            else load_first_package();
         end
         FuncNewMsg: begin
            load_first_package();
            eng_finished   = 1'b0;
            eng_collisions = '0;
            eng_losses     = '0;
            eng_sent       = '0;
         end
         default: ;
      endcase
      r.message_done    = eng_finished;
      r.backoff_left    = eng_backoff;
      r.collision_total = eng_collisions;
      r.loss_total      = eng_losses;
      r.sent_total      = eng_sent;
      return r;
   endfunction

   function automatic string format_report(input rsp_type r);
      return {$sformatf("grant=%0d sent=%0d pdone=%0d mdone=%0d status=%0d backoff=%0d",
                        r.access_granted, r.bits_sent, r.package_done, r.message_done,
                        r.status, r.backoff_left),
              $sformatf(" coll=%0d loss=%0d pkts=%0d",
                        r.collision_total, r.loss_total, r.sent_total)};
   endfunction

   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      string   bad;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.access_granted  = rsp_if.access_granted;
         got.bits_sent       = rsp_if.bits_sent;
         got.package_done    = rsp_if.package_done;
         got.message_done    = rsp_if.message_done;
         got.status          = rsp_if.status;
         got.backoff_left    = rsp_if.backoff_left;
         got.collision_total = rsp_if.collision_total;
         got.loss_total      = rsp_if.loss_total;
         got.sent_total      = rsp_if.sent_total;
         if (tx_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result beat with none expected: %s", $realtime,
                        format_report(got));
         end else begin
            want = tx_reports.pop_front();
            bad  = "";
            if (got.access_granted !== want.access_granted) bad = {bad, " access_granted"};
            if (got.bits_sent !== want.bits_sent) bad = {bad, " bits_sent"};
            if (got.package_done !== want.package_done) bad = {bad, " package_done"};
            if (got.message_done !== want.message_done) bad = {bad, " message_done"};
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.backoff_left !== want.backoff_left) bad = {bad, " backoff_left"};
            if (got.collision_total !== want.collision_total) bad = {bad, " collision_total"};
            if (got.loss_total !== want.loss_total) bad = {bad, " loss_total"};
            if (got.sent_total !== want.sent_total) bad = {bad, " sent_total"};
            if (bad != "") begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: mismatch in%s", $realtime, bad);
                  $display("   expected %s", format_report(want));
                  $display("   actual   %s", format_report(got));
               end
            end
         end
      end
   end

   // one event beat; returns at the falling edge after acceptance
   task automatic send_event(input logic [FuncWidth-1:0] func,
                             input logic [BitsWidth-1:0] cap = '0,
                             input logic [DrawWidth-1:0] draw = '0);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid         = 1'b1;
      req_if.func          = func;
      req_if.capacity_bits = cap;
      req_if.random_draw   = draw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = advance_engine(func, cap, draw);
      tx_reports.insert(tx_reports.size(), predicted);
      events_sent++;
      @(negedge clock);
   endtask

   // registers are only touched once every result beat is back
   task automatic drain_engine();
      req_if.valid = 1'b0;
      while (tx_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CountWidth-1:0] count,
                             input logic [BitsWidth-1:0] b0, b1, b2, b3,
                             input logic [LogWidth-1:0] init_win, max_win);
      write_reg(CsrPkgCount, CsrDataWidth'(count));
      write_reg(CsrPkgBits0, b0);
      write_reg(CsrPkgBits1, b1);
      write_reg(CsrPkgBits2, b2);
      write_reg(CsrPkgBits3, b3);
      write_reg(CsrInitWin, CsrDataWidth'(init_win));
      write_reg(CsrMaxWin, CsrDataWidth'(max_win));
      csr_wr_en       = 1'b0;
      cfg_pkg_count   = count;
      cfg_pkg_bits[0] = b0;
      cfg_pkg_bits[1] = b1;
      cfg_pkg_bits[2] = b2;
      cfg_pkg_bits[3] = b3;
      cfg_init_win    = init_win;
      cfg_max_win     = max_win;
   endtask

   function automatic logic [BitsWidth-1:0] pick_bits();
      case ($urandom_range(9))
         0:       return '1;
         1:       return BitsWidth'($urandom());
         2:       return BitsWidth'(1);
         default: return BitsWidth'($urandom_range(40, 1));
      endcase
   endfunction

   function automatic logic [LogWidth-1:0] pick_log2();
      return ($urandom_range(9) < 8) ? LogWidth'($urandom_range(10))
                                     : LogWidth'($urandom_range(15));
   endfunction

   // in half the picks near the bits left in the current package
   function automatic logic [BitsWidth-1:0] pick_capacity();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return eng_remaining;
         4:       return eng_remaining - 1'b1;
         5, 6:    return BitsWidth'($urandom_range(int'(eng_remaining)));
         7, 8:    return BitsWidth'($urandom_range(48));
         default: return BitsWidth'($urandom());
      endcase
   endfunction

   task automatic test_empty_message();
      send_event(FuncTick);
      send_event(FuncLoss, '1, '1);
      send_event(FuncCollision, '0, '1);
      send_event(FuncTick);
      send_event(FuncTick);
      send_event(FuncSpareA, '1, '1);
      send_event(FuncSpareB, '1, '1);
      // nothing loaded yet, so a zero capacity completes the lone package
      send_event(FuncTransmit, '0);
      send_event(FuncTransmit, '1);
      send_event(FuncLoss);
      send_event(FuncRestart);
      send_event(FuncCollision, '0, '0);
      send_event(FuncNewMsg);
      send_event(FuncTransmit, BitsWidth'(1));
   endtask

   task automatic test_segmentation();
      drain_engine();
      set_config(CountWidth'(4), 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, '0, LogWidth'(10));
      send_event(FuncNewMsg);
      send_event(FuncTransmit, '0);
      send_event(FuncTransmit, '1);
      send_event(FuncTransmit, BitsWidth'(1));
      send_event(FuncLoss);
      send_event(FuncLoss);
      send_event(FuncTransmit, 16'hFFFE);
      send_event(FuncTransmit, 16'h8000);
      send_event(FuncLoss);
      send_event(FuncTransmit, '1);
      // finished: transmit, loss and restart are refused, the rest still act
      send_event(FuncTransmit, '1);
      send_event(FuncLoss);
      send_event(FuncRestart);
      send_event(FuncTick);
      send_event(FuncCollision, '0, DrawWidth'(5));
      send_event(FuncNewMsg);
      send_event(FuncRestart);
   endtask

   task automatic test_backoff_window();
      drain_engine();
      set_config(CountWidth'(1), 16'd100, 16'd1, 16'd1, 16'd1, '0, LogWidth'(10));
      send_event(FuncNewMsg);
      // window doubles from 1 up to the 1024 ceiling
      repeat (11) send_event(FuncCollision, '0, '1);
      send_event(FuncTick);
      send_event(FuncTick);
      drain_engine();
      // initial window above the maximum is clamped to 1024, then falls to the maximum on a collision
      set_config(CountWidth'(1), 16'd100, 16'd1, 16'd1, 16'd1, LogWidth'(12), LogWidth'(3));
      send_event(FuncNewMsg);
      send_event(FuncCollision, '0, '1);
      send_event(FuncCollision, '0, '1);
      drain_engine();
      set_config(CountWidth'(1), 16'd100, 16'd1, 16'd1, 16'd1, '1, '1);
      send_event(FuncNewMsg);
      send_event(FuncCollision, '0, '1);
      send_event(FuncTick);
      drain_engine();
      set_config(CountWidth'(1), 16'd100, 16'd1, 16'd1, 16'd1, '0, '0);
      send_event(FuncRestart);
      send_event(FuncCollision, '0, '1);
      send_event(FuncCollision, '0, '0);
      send_event(FuncTick);
      send_event(FuncTick);
   endtask

   task automatic test_count_change();
      drain_engine();
      set_config(CountWidth'(4), 16'd8, 16'd8, 16'd8, 16'd8, LogWidth'(3), LogWidth'(10));
      send_event(FuncNewMsg);
      send_event(FuncTransmit, 16'd8);
      send_event(FuncTransmit, 16'd8);
      drain_engine();
      // count now below the index: the next full package ends the message
      set_config(CountWidth'(1), 16'd8, 16'd8, 16'd8, 16'd8, LogWidth'(3), LogWidth'(10));
      send_event(FuncTransmit, 16'd8);
      send_event(FuncLoss);
      drain_engine();
      set_config('0, 16'd5, 16'd6, 16'd7, 16'd8, LogWidth'(3), LogWidth'(10));
      send_event(FuncNewMsg);
      send_event(FuncTransmit, 16'd100);
      drain_engine();
      set_config('1, 16'd5, 16'd6, 16'd7, 16'd8, LogWidth'(3), LogWidth'(10));
      send_event(FuncNewMsg);
      repeat (5) send_event(FuncTransmit, '1);
   endtask

   task automatic test_random_messages(input int budget);
      int stop_at;
      int len;
      int pick;
      stop_at = events_sent + budget;
      while (events_sent < stop_at) begin
         if ($urandom_range(9) < 3) begin
            drain_engine();
            set_config(($urandom_range(9) < 7) ? CountWidth'($urandom_range(4, 1))
                                               : CountWidth'($urandom_range(7)),
                       pick_bits(), pick_bits(), pick_bits(), pick_bits(),
                       pick_log2(), pick_log2());
         end
         send_event(FuncNewMsg, BitsWidth'($urandom()), DrawWidth'($urandom()));
         len = $urandom_range(24, 4);
         repeat (len) begin
            pick = $urandom_range(99);
            if (pick < 20)
               send_event(FuncTick, BitsWidth'($urandom()), DrawWidth'($urandom()));
            else if (pick < 50)
               send_event(FuncTransmit, pick_capacity(), DrawWidth'($urandom()));
            else if (pick < 65)
               send_event(FuncCollision, BitsWidth'($urandom()), DrawWidth'($urandom()));
            else if (pick < 75)
               send_event(FuncLoss, BitsWidth'($urandom()), DrawWidth'($urandom()));
            else if (pick < 81)
               send_event(FuncRestart, BitsWidth'($urandom()), DrawWidth'($urandom()));
            else if (pick < 84)
               send_event(FuncNewMsg, BitsWidth'($urandom()), DrawWidth'($urandom()));
            else if (pick < 87)
               send_event($urandom_range(1) ? FuncSpareA : FuncSpareB,
                          BitsWidth'($urandom()), DrawWidth'($urandom()));
            else
               send_event(FuncTick);
         end
      end
   endtask

   initial begin
      req_if.valid         = 1'b0;
      req_if.func          = FuncTick;
      req_if.capacity_bits = '0;
      req_if.random_draw   = '0;
      rsp_if.ready         = 1'b0;

      cfg_pkg_count = CountWidth'(1);
      for (int i = 0; i < 4; i++) begin
         cfg_pkg_bits[i] = BitsWidth'(1);
         eng_marks[i]    = 1'b0;
      end
      cfg_init_win   = '0;
      cfg_max_win    = LogWidth'(10);
      eng_index      = '0;
      eng_remaining  = '0;
      eng_finished   = 1'b0;
      eng_window     = '0;
      eng_backoff    = '0;
      eng_collisions = '0;
      eng_losses     = '0;
      eng_sent       = '0;

      repeat (12) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 10;
      recv_idle_pct = 70;
      test_empty_message();
      test_segmentation();
      test_random_messages(150);

      send_idle_pct = 70;
      recv_idle_pct = 10;
      test_backoff_window();
      test_count_change();
      test_random_messages(150);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_messages(160);

      req_if.valid = 1'b0;
      while (tx_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

@@ backoff_segmented_transmitter.f @@
+incdir+rtl/core
rtl/core/bst_pkg.sv
rtl/core/bst_req_if.sv
rtl/core/bst_rsp_if.sv
rtl/core/backoff_segmented_transmitter.sv
dv/tb_backoff_segmented_transmitter.sv
